### design/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Types, constants and digit-counter helpers for the countdown clock
// controller. The clock value is kept as minute, second and millisecond
// digit counters.
// ----------------------------------------------------------------------------
package ccc_pkg;

    localparam int unsigned CFG_AW = 4;
    localparam int unsigned CFG_DW = 32;

    localparam logic [21:0] MAX_CLOCK_MS     = 22'd3599999;
    localparam logic [4:0]  MAX_VOLUME       = 5'd30;
    localparam logic [3:0]  BLANK_DIGIT      = 4'd10;
    localparam logic [9:0]  MS_TOP           = 10'd999;

    localparam logic [21:0] RST_DURATION_MS  = 22'd180000;
    localparam logic [11:0] RST_THRESHOLD    = 12'd2048;
    localparam logic [11:0] RST_START_DELAY  = 12'd3500;
    localparam logic [4:0]  RST_VOLUME       = 5'd20;

    // reciprocal of 125 for (x >> 3) / 125, and of 15 for (q >> 2) / 15
    localparam logic [19:0] RECIP_125        = 20'd536871;
    localparam int unsigned RECIP_125_SHIFT  = 26;
    localparam logic [10:0] RECIP_15         = 11'd1093;
    localparam int unsigned RECIP_15_SHIFT   = 14;

    typedef enum logic [1:0] {
        REG_DURATION  = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_DELAY     = 2'd2,
        REG_VOLUME    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic        start_switch;
        logic        dial_button;
        logic [11:0] pulse_sample;
        logic [11:0] direction_sample;
    } t_in;

    typedef struct packed {
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [3:0] digit_thousands;
        logic [3:0] digit_hundreds;
        logic [3:0] digit_tens;
        logic [3:0] digit_ones;
        logic       running;
        logic       edit_time;
        logic [4:0] volume_level;
        logic       buzzer_pulse;
        logic       start_sound;
        logic       display_changed;
    } t_out;

    typedef struct packed {
        logic [2:0] mt;
        logic [3:0] mo;
        logic [2:0] st;
        logic [3:0] so;
        logic [9:0] ms;
    } t_clk;

    typedef struct packed {
        logic [11:0] threshold;
        logic [11:0] start_delay;
        t_clk        dur_clk;
        logic        vol_load;
        logic [4:0]  vol_value;
        logic        busy;
    } t_cfg;

    localparam t_clk RST_DUR_CLK = '{mt: 3'd0, mo: 4'd3, st: 3'd0, so: 4'd0, ms: 10'd0};
    localparam t_clk ZERO_CLK    = '{mt: 3'd0, mo: 4'd0, st: 3'd0, so: 4'd0, ms: 10'd0};

    function automatic logic clk_secs_zero(input t_clk c);
        return (c.mt == 3'd0) && (c.mo == 4'd0) && (c.st == 3'd0) && (c.so == 4'd0);
    endfunction

    function automatic logic clk_is_zero(input t_clk c);
        return clk_secs_zero(c) && (c.ms == 10'd0);
    endfunction

    function automatic t_clk clk_dec(input t_clk c);
        t_clk r;
        r = c;
        if (c.ms != 10'd0) begin
            r.ms = c.ms - 10'd1;
        end else begin
            r.ms = MS_TOP;
            if (c.so != 4'd0) begin
                r.so = c.so - 4'd1;
            end else begin
                r.so = 4'd9;
                if (c.st != 3'd0) begin
                    r.st = c.st - 3'd1;
                end else begin
                    r.st = 3'd5;
                    if (c.mo != 4'd0) begin
                        r.mo = c.mo - 4'd1;
                    end else begin
                        r.mo = 4'd9;
                        r.mt = c.mt - 3'd1;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic t_clk clk_add_sec(input t_clk c);
        t_clk r;
        r = c;
        if ((c.mt == 3'd5) && (c.mo == 4'd9) && (c.st == 3'd5) && (c.so == 4'd9)) begin
            r.ms = MS_TOP;
        end else if (c.so != 4'd9) begin
            r.so = c.so + 4'd1;
        end else begin
            r.so = 4'd0;
            if (c.st != 3'd5) begin
                r.st = c.st + 3'd1;
            end else begin
                r.st = 3'd0;
                if (c.mo != 4'd9) begin
                    r.mo = c.mo + 4'd1;
                end else begin
                    r.mo = 4'd0;
                    r.mt = c.mt + 3'd1;
                end
            end
        end
        return r;
    endfunction

    function automatic t_clk clk_sub_sec(input t_clk c);
        t_clk r;
        r = c;
        if (clk_secs_zero(c)) begin
            r = ZERO_CLK;
        end else if (c.so != 4'd0) begin
            r.so = c.so - 4'd1;
        end else begin
            r.so = 4'd9;
            if (c.st != 3'd0) begin
                r.st = c.st - 3'd1;
            end else begin
                r.st = 3'd5;
                if (c.mo != 4'd0) begin
                    r.mo = c.mo - 4'd1;
                end else begin
                    r.mo = 4'd9;
                    r.mt = c.mt - 3'd1;
                end
            end
        end
        return r;
    endfunction

    // tens digit of a value below 60
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd50) begin
            t = 3'd5;
        end else if (v >= 6'd40) begin
            t = 3'd4;
        end else if (v >= 6'd30) begin
            t = 3'd3;
        end else if (v >= 6'd20) begin
            t = 3'd2;
        end else if (v >= 6'd10) begin
            t = 3'd1;
        end else begin
            t = 3'd0;
        end
        return t;
    endfunction

    function automatic logic [5:0] times10(input logic [2:0] t);
        return ({3'd0, t} << 3) + ({3'd0, t} << 1);
    endfunction

endpackage

### design/countdown_clock_controller.sv
// ----------------------------------------------------------------------------
// countdown_clock_controller
// Millisecond-tick countdown clock with dial edit mode, encoder adjust,
// volume and buzzer pulses.
//
//   channel  direction  payload  handshake
//   in       request    t_in     i_in_valid / o_in_stall
//   out      result     t_out    o_out_valid / i_out_stall
//   cfg      APB write  32 bit   psel / penable / pwrite / pready
//
// One request per cycle while the config is not busy and the result is not
// stalled; each request passes the input register, then the result register
// around one pass of step logic. After a write of the duration register,
// requests stall while the duration is split into digits.
// Synchronous active-low reset; no clearing pass.
// A stalled result holds while the input register still takes one request.
// ----------------------------------------------------------------------------
module countdown_clock_controller
    import ccc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    t_cfg cfg;
    t_in  r_in;
    logic r_in_vld;
    t_out r_out;
    logic r_out_vld;
    t_out result;
    logic advance;
    logic in_ready;

    ccc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ccc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign in_ready   = !cfg.busy && (!r_in_vld || advance);
    assign o_in_stall = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in_valid && in_ready) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && in_ready) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

### design/ccc_cfg.sv
// ----------------------------------------------------------------------------
// ccc_cfg
// APB register file. Splits the set duration into minute, second and
// millisecond digits over a three-stage pipeline and flags busy meanwhile.
// ----------------------------------------------------------------------------
module ccc_cfg
    import ccc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [21:0] r_duration;
    logic [11:0] r_threshold;
    logic [11:0] r_delay;
    logic [4:0]  r_volume;
    logic [1:0]  r_conv_cnt;
    logic        r_vol_load;
    logic [4:0]  r_vol_value;

    logic [11:0] r_s1_q;
    logic [21:0] r_s1_c;
    logic [11:0] r_s2_q;
    logic [9:0]  r_s2_ms;
    logic [5:0]  r_s2_mins;
    t_clk        r_dur_clk;

    logic        wr;
    t_reg_idx    idx;
    logic [21:0] c_clamp;
    logic [38:0] prod1;
    logic [21:0] q_x1000;
    logic [21:0] ms_full;
    logic [20:0] prod2;
    logic [11:0] mins_x60;
    logic [11:0] secs_full;
    logic [5:0]  secs;
    logic [5:0]  mins;
    logic [2:0]  st;
    logic [2:0]  mt;
    logic [5:0]  so_full;
    logic [5:0]  mo_full;
    t_clk        n_dur_clk;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[3:2]);

    always_comb begin
        case (idx)
            REG_DURATION:  prdata = {10'd0, r_duration};
            REG_THRESHOLD: prdata = {20'd0, r_threshold};
            REG_DELAY:     prdata = {20'd0, r_delay};
            REG_VOLUME:    prdata = {27'd0, r_volume};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration  <= RST_DURATION_MS;
            r_threshold <= RST_THRESHOLD;
            r_delay     <= RST_START_DELAY;
            r_volume    <= RST_VOLUME;
            r_conv_cnt  <= 2'd0;
            r_vol_load  <= 1'b0;
            r_dur_clk   <= RST_DUR_CLK;
        end else begin
            r_vol_load <= 1'b0;
            if (r_conv_cnt != 2'd0) begin
                r_conv_cnt <= r_conv_cnt - 2'd1;
            end
            if (r_conv_cnt == 2'd1) begin
                r_dur_clk <= n_dur_clk;
            end
            if (wr) begin
                case (idx)
                    REG_DURATION: begin
                        r_duration <= pwdata[21:0];
                        r_conv_cnt <= 2'd3;
                    end
                    REG_THRESHOLD: r_threshold <= pwdata[11:0];
                    REG_DELAY:     r_delay     <= pwdata[11:0];
                    REG_VOLUME: begin
                        r_volume   <= pwdata[4:0];
                        r_vol_load <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vol_value <= (pwdata[4:0] > MAX_VOLUME) ? MAX_VOLUME : pwdata[4:0];
    end

    // stage 1: whole seconds by reciprocal of 1000
    assign c_clamp = (r_duration > MAX_CLOCK_MS) ? MAX_CLOCK_MS : r_duration;
    assign prod1   = {20'd0, c_clamp[21:3]} * {19'd0, RECIP_125};

    // stage 2: millisecond remainder and whole minutes
    assign q_x1000 = ({10'd0, r_s1_q} << 10) - ({10'd0, r_s1_q} << 4)
                   - ({10'd0, r_s1_q} << 3);
    assign ms_full = r_s1_c - q_x1000;
    assign prod2   = {11'd0, r_s1_q[11:2]} * {10'd0, RECIP_15};

    // stage 3: seconds and decimal digits
    assign mins_x60  = ({6'd0, r_s2_mins} << 6) - ({6'd0, r_s2_mins} << 2);
    assign secs_full = r_s2_q - mins_x60;
    assign secs      = secs_full[5:0];
    assign mins      = r_s2_mins;
    assign st        = tens_of(secs);
    assign mt        = tens_of(mins);
    assign so_full   = secs - times10(st);
    assign mo_full   = mins - times10(mt);

    always_comb begin
        n_dur_clk.mt = mt;
        n_dur_clk.mo = mo_full[3:0];
        n_dur_clk.st = st;
        n_dur_clk.so = so_full[3:0];
        n_dur_clk.ms = r_s2_ms;
    end

    always_ff @(posedge i_clk) begin
        r_s1_q    <= prod1[RECIP_125_SHIFT+11:RECIP_125_SHIFT];
        r_s1_c    <= c_clamp;
        r_s2_q    <= r_s1_q;
        r_s2_ms   <= ms_full[9:0];
        r_s2_mins <= prod2[RECIP_15_SHIFT+5:RECIP_15_SHIFT];
    end

    always_comb begin
        o_cfg.threshold   = r_threshold;
        o_cfg.start_delay = r_delay;
        o_cfg.dur_clk     = r_dur_clk;
        o_cfg.vol_load    = r_vol_load;
        o_cfg.vol_value   = r_vol_value;
        o_cfg.busy        = (r_conv_cnt != 2'd0);
    end

`ifndef SYNTHESIS
    a_conv_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && idx == REG_DURATION) |=> (r_conv_cnt == 2'd3))
        else $error("duration write did not start conversion");

    a_conv_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_conv_cnt == 2'd1 && !wr) |=> (r_conv_cnt == 2'd0 && !o_cfg.busy))
        else $error("conversion did not finish");

    a_dur_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_conv_cnt == 2'd1) |=> (r_dur_clk.mt <= 3'd5 && r_dur_clk.mo <= 4'd9
            && r_dur_clk.st <= 3'd5 && r_dur_clk.so <= 4'd9 && r_dur_clk.ms <= MS_TOP))
        else $error("duration digits out of range");
`endif

endmodule

### design/ccc_core.sv
// ----------------------------------------------------------------------------
// ccc_core
// Clock state and the per-tick update: dial, run mode, countdown, buzzer,
// encoder edits. Produces the result for the request being processed.
// ----------------------------------------------------------------------------
module ccc_core
    import ccc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output t_out o_result
);

    t_clk        r_clk;
    t_clk        r_prev;
    logic        r_run;
    logic        r_edit;
    logic        r_dial;
    logic        r_armed;
    logic [4:0]  r_vol;
    logic [11:0] r_start_wait;

    t_clk        n_clk;
    t_clk        n_prev;
    logic        n_run;
    logic        n_edit;
    logic        n_dial;
    logic        n_armed;
    logic [4:0]  n_vol;
    logic [11:0] n_start_wait;

    t_clk        clk_a;
    t_clk        clk_b;
    t_clk        clk_c;
    t_clk        show;
    logic        started;
    logic        buzz;
    logic        changed;
    logic        pulse_hi;
    logic        pulse_lo;
    logic        dir_up;
    logic        dir_dn;
    logic        waiting;
    logic [4:0]  vol_a;

    assign waiting  = (r_start_wait != 12'd0);
    assign pulse_hi = (i_item.pulse_sample >= i_cfg.threshold);
    assign pulse_lo = (i_item.pulse_sample <= i_cfg.threshold);
    assign dir_up   = (i_item.direction_sample >= i_cfg.threshold);
    assign dir_dn   = (i_item.direction_sample <= i_cfg.threshold);

    always_comb begin
        n_clk        = r_clk;
        n_prev       = r_prev;
        n_run        = r_run;
        n_edit       = r_edit;
        n_dial       = r_dial;
        n_armed      = r_armed;
        n_vol        = r_vol;
        n_start_wait = r_start_wait;
        clk_a        = r_clk;
        clk_b        = r_clk;
        clk_c        = r_clk;
        vol_a        = r_vol;
        started      = 1'b0;
        buzz         = 1'b0;
        changed      = 1'b0;

        if (waiting) begin
            n_start_wait = r_start_wait - 12'd1;
        end else begin
            if (!r_dial && i_item.dial_button) begin
                n_dial = 1'b1;
                n_edit = !r_edit;
            end else if (r_dial && !i_item.dial_button) begin
                n_dial = 1'b0;
                clk_a  = i_cfg.dur_clk;
            end

            if (!r_run && i_item.start_switch) begin
                n_run        = 1'b1;
                started      = 1'b1;
                n_start_wait = i_cfg.start_delay;
            end else if (r_run && !i_item.start_switch) begin
                n_run = 1'b0;
            end

            clk_b = clk_a;
            if (n_run && !started && !clk_is_zero(clk_a)) begin
                clk_b = clk_dec(clk_a);
            end

            buzz = (clk_b.mt == 3'd0) && (clk_b.mo == 4'd0) && (clk_b.st == 3'd0)
                && (r_prev.st == 3'd0)
                && (r_prev.so >= 4'd1) && (r_prev.so <= 4'd4)
                && (clk_b.so + 4'd1 == r_prev.so);
            changed = (clk_b != r_prev);
            n_prev  = clk_b;

            clk_c = clk_b;
            vol_a = r_vol;
            if (pulse_hi && !r_armed) begin
                n_armed = 1'b1;
                if (!n_run) begin
                    if (n_edit) begin
                        if (dir_up) begin
                            clk_c = clk_add_sec(clk_c);
                        end
                        if (dir_dn) begin
                            clk_c = clk_sub_sec(clk_c);
                        end
                    end else begin
                        if (dir_up && vol_a < MAX_VOLUME) begin
                            vol_a = vol_a + 5'd1;
                        end
                        if (dir_dn && vol_a > 5'd0) begin
                            vol_a = vol_a - 5'd1;
                        end
                    end
                end
            end else if (pulse_lo && r_armed) begin
                n_armed = 1'b0;
            end
            n_clk = clk_c;
            n_vol = vol_a;
        end
    end

    assign show = waiting ? r_clk : clk_b;

    always_comb begin
        o_result.minutes         = times10(show.mt) + {2'd0, show.mo};
        o_result.seconds         = times10(show.st) + {2'd0, show.so};
        o_result.digit_thousands = (show.mt == 3'd0) ? BLANK_DIGIT : {1'b0, show.mt};
        o_result.digit_hundreds  = (show.mt == 3'd0 && show.mo == 4'd0) ? BLANK_DIGIT
                                 : show.mo;
        o_result.digit_tens      = (show.mt == 3'd0 && show.mo == 4'd0 && show.st == 3'd0)
                                 ? BLANK_DIGIT : {1'b0, show.st};
        o_result.digit_ones      = show.so;
        o_result.running         = waiting ? r_run : n_run;
        o_result.edit_time       = waiting ? r_edit : n_edit;
        o_result.volume_level    = r_vol;
        o_result.buzzer_pulse    = buzz;
        o_result.start_sound     = started;
        o_result.display_changed = changed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk        <= RST_DUR_CLK;
            r_prev       <= RST_DUR_CLK;
            r_run        <= 1'b0;
            r_edit       <= 1'b0;
            r_dial       <= 1'b0;
            r_armed      <= 1'b0;
            r_vol        <= RST_VOLUME;
            r_start_wait <= 12'd0;
        end else if (i_fire) begin
            r_clk        <= n_clk;
            r_prev       <= n_prev;
            r_run        <= n_run;
            r_edit       <= n_edit;
            r_dial       <= n_dial;
            r_armed      <= n_armed;
            r_vol        <= i_cfg.vol_load ? i_cfg.vol_value : n_vol;
            r_start_wait <= n_start_wait;
        end else if (i_cfg.vol_load) begin
            r_vol <= i_cfg.vol_value;
        end
    end

`ifndef SYNTHESIS
    a_wait_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_start_wait != 12'd0) |-> r_run)
        else $error("start wait outside running mode");

    a_clk_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clk.mt <= 3'd5 && r_clk.mo <= 4'd9 && r_clk.st <= 3'd5
            && r_clk.so <= 4'd9 && r_clk.ms <= MS_TOP)
        else $error("clock digits out of range");

    a_wait_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && waiting && !i_cfg.vol_load) |=>
            ($stable(r_clk) && $stable(r_vol) && $stable(r_edit) && $stable(r_armed)))
        else $error("state moved during start wait");
`endif

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for countdown_clock_controller. A queue of tick
// requests feeds a clocked driver, and a clocked monitor compares every result
// against a cycle-free model of the clock, dial, encoder and volume logic.
// Phases reconfigure the block over the APB port between drained runs. They
// cover directed edge cases, a long start wait and random well-formed
// dial, encoder and start sequences, with random gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench
    import ccc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_AT     = 100;
    localparam int HOLD_CYCLES = 80;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in               i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out              o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [CFG_AW-1:0] paddr       = '0;
    logic [CFG_DW-1:0] pwdata      = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    countdown_clock_controller DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    t_in  tick_queue[$];
    t_out expected_display[$];
    t_out due;
    int   ticks_made   = 0;
    int   results_seen = 0;
    int   hold_left    = 0;
    int   mismatches   = 0;
    int   idle_pct     = 36;

    logic [21:0] set_duration  = RST_DURATION_MS;
    logic [11:0] set_threshold = RST_THRESHOLD;
    logic [11:0] set_delay     = RST_START_DELAY;
    logic [4:0]  set_volume    = RST_VOLUME;

    logic [21:0] clk_ms      = RST_DURATION_MS;
    logic [21:0] prev_clk_ms = RST_DURATION_MS;
    logic        run_on      = 1'b0;
    logic        edit_on     = 1'b0;
    logic        dial_held   = 1'b0;
    logic        enc_armed   = 1'b0;
    logic [4:0]  vol         = RST_VOLUME;
    logic [11:0] wait_ms     = '0;

    function automatic logic [21:0] loaded_duration();
        return (set_duration > MAX_CLOCK_MS) ? MAX_CLOCK_MS : set_duration;
    endfunction

    function automatic t_out show_clock(input logic buzz, input logic started,
                                        input logic changed);
        t_out        r;
        int unsigned s;
        int unsigned m;
        s = clk_ms / 1000;
        m = (s / 60) % 60;
        s = s % 60;
        r.minutes         = 6'(m);
        r.seconds         = 6'(s);
        r.digit_thousands = (m / 10 != 0) ? 4'(m / 10) : BLANK_DIGIT;
        r.digit_hundreds  = (m != 0) ? 4'(m % 10) : BLANK_DIGIT;
        r.digit_tens      = (s / 10 != 0 || m != 0) ? 4'(s / 10) : BLANK_DIGIT;
        r.digit_ones      = 4'(s % 10);
        r.running         = run_on;
        r.edit_time       = edit_on;
        r.volume_level    = vol;
        r.buzzer_pulse    = buzz;
        r.start_sound     = started;
        r.display_changed = changed;
        return r;
    endfunction

    function automatic t_out predict_tick(input t_in t);
        t_out        r;
        logic        started;
        logic        buzz;
        logic        changed;
        int unsigned secs;
        int unsigned mins;
        int unsigned prev_secs;
        int unsigned bumped;
        started = 1'b0;
        if (wait_ms != 0) begin
            wait_ms = wait_ms - 12'd1;
            return show_clock(1'b0, 1'b0, 1'b0);
        end
        if (!dial_held && t.dial_button) begin
            dial_held = 1'b1;
            edit_on   = !edit_on;
        end else if (dial_held && !t.dial_button) begin
            clk_ms    = loaded_duration();
            dial_held = 1'b0;
        end
        if (!run_on && t.start_switch) begin
            run_on  = 1'b1;
            started = 1'b1;
            wait_ms = set_delay;
        end else if (run_on && !t.start_switch) begin
            run_on = 1'b0;
        end
        if (run_on && !started && clk_ms != 0) begin
            clk_ms = clk_ms - 22'd1;
        end
        secs      = clk_ms / 1000;
        mins      = (secs / 60) % 60;
        secs      = secs % 60;
        prev_secs = (prev_clk_ms / 1000) % 60;
        buzz      = (mins == 0) && (prev_secs >= 1) && (prev_secs <= 4)
                    && (secs + 1 == prev_secs);
        changed     = (clk_ms != prev_clk_ms);
        prev_clk_ms = clk_ms;
        r = show_clock(buzz, started, changed);
        if (t.pulse_sample >= set_threshold && !enc_armed) begin
            enc_armed = 1'b1;
            if (t.direction_sample >= set_threshold && !run_on) begin
                if (edit_on) begin
                    bumped = clk_ms + 1000;
                    clk_ms = (bumped > MAX_CLOCK_MS) ? MAX_CLOCK_MS : 22'(bumped);
                end else if (vol < MAX_VOLUME) begin
                    vol = vol + 5'd1;
                end
            end
            if (t.direction_sample <= set_threshold && !run_on) begin
                if (edit_on) begin
                    clk_ms = (clk_ms >= 1000) ? clk_ms - 22'd1000 : '0;
                end else if (vol > 0) begin
                    vol = vol - 5'd1;
                end
            end
        end else if (t.pulse_sample <= set_threshold && enc_armed) begin
            enc_armed = 1'b0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    task automatic add_tick(input logic sw, input logic dial,
                            input logic [11:0] pulse, input logic [11:0] dir);
        t_in t;
        t.start_switch     = sw;
        t.dial_button      = dial;
        t.pulse_sample     = pulse;
        t.direction_sample = dir;
        tick_queue.push_back(t);
        ticks_made++;
    endtask

    function automatic logic [11:0] low_pulse();
        return (set_threshold == 0) ? 12'd0 : 12'($urandom_range(set_threshold - 1, 0));
    endfunction

    function automatic logic [11:0] high_pulse();
        return 12'($urandom_range(4095, set_threshold));
    endfunction

    function automatic logic [11:0] pick_direction();
        logic [11:0] d;
        case ($urandom_range(0, 2))
            0: d = 12'($urandom_range(4095, set_threshold));
            1: d = 12'($urandom_range(set_threshold, 0));
            default: d = set_threshold;
        endcase
        return d;
    endfunction

    task automatic set_register(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_DURATION:  set_duration  = value[21:0];
            REG_THRESHOLD: set_threshold = value[11:0];
            REG_DELAY:     set_delay     = value[11:0];
            REG_VOLUME: begin
                set_volume = value[4:0];
                vol        = (value[4:0] > MAX_VOLUME) ? MAX_VOLUME : value[4:0];
            end
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (tick_queue.size() != 0 || i_in_valid || expected_display.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n);
        int   first;
        int   len;
        int   i;
        logic sw;
        logic dial;
        first = ticks_made;
        sw    = 1'b0;
        dial  = 1'b0;
        while (ticks_made - first < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    add_tick(sw, dial, high_pulse(), pick_direction());
                    add_tick(sw, dial, low_pulse(), 12'($urandom));
                end
                4, 5: begin
                    dial = 1'b1;
                    len  = $urandom_range(1, 3);
                    repeat (len) add_tick(sw, dial, low_pulse(), 12'($urandom));
                    dial = 1'b0;
                    add_tick(sw, dial, low_pulse(), 12'($urandom));
                end
                6, 7: begin
                    sw  = 1'b1;
                    len = set_delay + $urandom_range(1, 40);
                    for (i = 0; i < len; i++) begin
                        add_tick(sw, dial, 12'($urandom), 12'($urandom));
                    end
                    sw = 1'b0;
                    add_tick(sw, dial, low_pulse(), 12'($urandom));
                end
                8: begin
                    len = $urandom_range(1, 3);
                    repeat (len) begin
                        sw   = 1'($urandom);
                        dial = 1'($urandom);
                        add_tick(sw, dial, 12'($urandom), 12'($urandom));
                    end
                end
                default: begin
                    len = $urandom_range(1, 5);
                    repeat (len) add_tick(sw, dial, low_pulse(), 12'($urandom));
                end
            endcase
        end
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_display.push_back(predict_tick(i_in_data));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (tick_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= tick_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_display.size() == 0) begin
                    $error("result with no pending request");
                    mismatches++;
                end else begin
                    due = expected_display.pop_front();
                    check_field("minutes", due.minutes, o_out_data.minutes);
                    check_field("seconds", due.seconds, o_out_data.seconds);
                    check_field("digit_thousands", due.digit_thousands,
                                o_out_data.digit_thousands);
                    check_field("digit_hundreds", due.digit_hundreds,
                                o_out_data.digit_hundreds);
                    check_field("digit_tens", due.digit_tens, o_out_data.digit_tens);
                    check_field("digit_ones", due.digit_ones, o_out_data.digit_ones);
                    check_field("running", due.running, o_out_data.running);
                    check_field("edit_time", due.edit_time, o_out_data.edit_time);
                    check_field("volume_level", due.volume_level,
                                o_out_data.volume_level);
                    check_field("buzzer_pulse", due.buzzer_pulse,
                                o_out_data.buzzer_pulse);
                    check_field("start_sound", due.start_sound, o_out_data.start_sound);
                    check_field("display_changed", due.display_changed,
                                o_out_data.display_changed);
                end
                if (results_seen == HOLD_AT) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < idle_pct);
            end
        end
    end

    initial begin
        int k;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: volume steps, both-way step at threshold, time edit
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        add_tick(1'b0, 1'b0, 12'd4095, 12'd4095);
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        add_tick(1'b0, 1'b0, 12'd4095, 12'd0);
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        add_tick(1'b0, 1'b0, 12'd2048, 12'd2048);
        add_tick(1'b0, 1'b0, 12'd2048, 12'd0);
        add_tick(1'b0, 1'b1, 12'd0, 12'd0);
        add_tick(1'b0, 1'b1, 12'd4095, 12'd4095);
        add_tick(1'b0, 1'b1, 12'd0, 12'd0);
        add_tick(1'b0, 1'b1, 12'd4095, 12'd0);
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        wait_drained();

        // short duration: volume ceiling, start tick, last-second buzzer, floor at zero
        set_register(REG_DURATION, 32'd1005);
        set_register(REG_THRESHOLD, 32'd2048);
        set_register(REG_DELAY, 32'd0);
        set_register(REG_VOLUME, 32'd31);
        add_tick(1'b0, 1'b1, 12'd0, 12'd0);
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        add_tick(1'b0, 1'b0, 12'd4095, 12'd4095);
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        add_tick(1'b0, 1'b1, 12'd0, 12'd0);
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        add_tick(1'b1, 1'b0, 12'd0, 12'd0);
        add_tick(1'b1, 1'b0, 12'd4095, 12'd4095);
        repeat (6) add_tick(1'b1, 1'b0, 12'd0, 12'd0);
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        add_tick(1'b0, 1'b0, 12'd4095, 12'd0);
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        add_tick(1'b0, 1'b0, 12'd4095, 12'd0);
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        add_tick(1'b0, 1'b0, 12'd4095, 12'd4095);
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        wait_drained();

        // duration and threshold maxima, time ceiling, volume floor, long start wait,
        // no idling
        idle_pct = 0;
        set_register(REG_DURATION, 32'h003F_FFFF);
        set_register(REG_THRESHOLD, 32'd4095);
        set_register(REG_DELAY, 32'd400);
        set_register(REG_VOLUME, 32'd0);
        repeat (edit_on ? 2 : 1) begin
            add_tick(1'b0, 1'b1, 12'd0, 12'd0);
            add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        end
        add_tick(1'b0, 1'b0, 12'd4095, 12'd4095);
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        add_tick(1'b0, 1'b1, 12'd0, 12'd0);
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        add_tick(1'b0, 1'b0, 12'd4095, 12'd0);
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        add_tick(1'b1, 1'b0, 12'd0, 12'd0);
        repeat (400) add_tick(1'($urandom), 1'($urandom), 12'($urandom), 12'($urandom));
        repeat (20) add_tick(1'b1, 1'b0, 12'($urandom), 12'($urandom));
        add_tick(1'b0, 1'b0, 12'd0, 12'd0);
        wait_drained();
        idle_pct = 36;

        for (k = 0; k < 6; k++) begin
            case ($urandom_range(0, 7))
                6:       set_register(REG_DURATION, 32'($urandom_range(0, 4194303)));
                7:       set_register(REG_DURATION, 32'(MAX_CLOCK_MS));
                default: set_register(REG_DURATION,
                                      32'($urandom_range(0, 5) * 1000
                                          + $urandom_range(0, 40)));
            endcase
            case ($urandom_range(0, 5))
                0:       set_register(REG_THRESHOLD, 32'd0);
                1:       set_register(REG_THRESHOLD, 32'd4095);
                2, 3:    set_register(REG_THRESHOLD, 32'd2048);
                default: set_register(REG_THRESHOLD, 32'($urandom_range(0, 4095)));
            endcase
            set_register(REG_DELAY, 32'($urandom_range(0, 12)));
            set_register(REG_VOLUME, 32'($urandom_range(0, 31)));
            random_phase(100);
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_display.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
